// ----- rtl/tid_pkg.sv -----
// tid_pkg: shared types, codes and constants for the timestamped input debouncer
// no dependencies

package tid_pkg;

   localparam int unsigned US_PER_MS         = 1000;
   localparam int unsigned NUM_CHANNELS_DEF  = 2;
   localparam int unsigned TIME_W            = 63;
   localparam int unsigned WINDOW_W          = 16;
   localparam int unsigned WIN_US_W          = 26;
   localparam int unsigned COUNT_W           = 32;
   localparam int unsigned ADDR_W            = 3;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd50;

   localparam logic FUNC_INIT = 1'b0;
   localparam logic FUNC_POLL = 1'b1;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_INIT  = 2'd1;
   localparam logic [1:0] STATUS_BAD_CHAN  = 2'd2;

   localparam logic REG_WINDOW   = 1'b0;
   localparam logic REG_POLARITY = 1'b1;

   typedef struct packed {
      logic              func;
      logic              raw_level;
      logic [TIME_W-1:0] now_us;
      logic [1:0]        channel;
   } item_type;

   typedef struct packed {
      logic [WIN_US_W-1:0] win_us;
      logic                invert;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [1:0]         channel_echo;
      logic [TIME_W-1:0]  sample_time_us;
      logic [COUNT_W-1:0] value;
   } result_type;

endpackage

// ----- rtl/timestamped_input_debouncer.sv -----
// timestamped_input_debouncer: top level, input register, result register, csr and eval
// depends on tid_pkg, tid_csr, tid_eval
//
//   channel   direction   handshake              payload
//   req       in          req_tvalid/req_tready  req_tdata, req_tuser
//   rsp       out         rsp_tvalid/rsp_tready  rsp_tdata
//   csr       in          psel/penable/pready    paddr, pwdata, prdata
//
// one transaction per cycle sustained while rsp_tready keeps the result register free; each one
// is held in the input register and then moves to the result register, from which the result is
// presented. the rate is set by the state update in tid_eval.
// synchronous reset clears valids, debounce state and registers to their defaults.
// a stalled result holds; a new transaction is still taken while the input register is free.

module timestamped_input_debouncer #(
   parameter int NUM_CHANNELS = tid_pkg::NUM_CHANNELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [71:0]                 req_tdata,  // raw_level, now_us[62:0], channel[1:0], zeros
   input  logic [0:0]                  req_tuser,  // func
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [103:0]                rsp_tdata,  // status[1:0], channel_echo[1:0],
                                                   // sample_time_us[62:0], value[31:0], zeros
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tid_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);

   logic                 in_valid_ff, in_valid_in;
   tid_pkg::item_type    item_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   tid_pkg::result_type  result_ff;
   tid_pkg::result_type  result;
   tid_pkg::cfg_type     cfg;
   logic                 out_free;
   logic                 advance;
   logic                 req_fire;

   tid_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tid_eval #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_eval (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff.func      <= req_tuser[0];
         item_ff.raw_level <= req_tdata[0];
         item_ff.now_us    <= req_tdata[63:1];
         item_ff.channel   <= req_tdata[65:64];
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, result_ff.value, result_ff.sample_time_us,
                        result_ff.channel_echo, result_ff.status};

endmodule

// ----- rtl/tid_csr.sv -----
// tid_csr: register block behind the configuration port
// depends on tid_pkg

module tid_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [tid_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output tid_pkg::cfg_type            cfg
);

   logic [tid_pkg::WINDOW_W-1:0] window_ff, window_in;
   logic [tid_pkg::WIN_US_W-1:0] win_us_ff, win_us_in;
   logic                         invert_ff, invert_in;
   logic                         wr_en;
   logic                         reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      window_in = window_ff;
      win_us_in = win_us_ff;
      invert_in = invert_ff;
      if (wr_en) begin
         unique case (reg_idx)
            tid_pkg::REG_WINDOW: begin
               window_in = pwdata[tid_pkg::WINDOW_W-1:0];
               win_us_in = tid_pkg::WIN_US_W'(pwdata[tid_pkg::WINDOW_W-1:0])
                         * tid_pkg::WIN_US_W'(tid_pkg::US_PER_MS);
            end
            tid_pkg::REG_POLARITY: begin
               invert_in = pwdata[0];
            end
            default: begin
               invert_in = invert_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= tid_pkg::WINDOW_RESET;
         win_us_ff <= tid_pkg::WIN_US_W'(tid_pkg::WINDOW_RESET)
                    * tid_pkg::WIN_US_W'(tid_pkg::US_PER_MS);
         invert_ff <= 1'b0;
      end else begin
         window_ff <= window_in;
         win_us_ff <= win_us_in;
         invert_ff <= invert_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         tid_pkg::REG_WINDOW:   prdata = {16'd0, window_ff};
         tid_pkg::REG_POLARITY: prdata = {31'd0, invert_ff};
         default:               prdata = 32'd0;
      endcase
   end

   assign cfg.win_us = win_us_ff;
   assign cfg.invert = invert_ff;

endmodule

// ----- rtl/tid_eval.sv -----
// tid_eval: debounce state and the single-pass evaluation of one transaction
// depends on tid_pkg

module tid_eval #(
   parameter int NUM_CHANNELS = tid_pkg::NUM_CHANNELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  tid_pkg::item_type    item,
   input  tid_pkg::cfg_type     cfg,
   output tid_pkg::result_type  result
);

   localparam logic [2:0] CH_LIMIT = 3'(NUM_CHANNELS);

   logic                         started_ff, started_in;
   logic                         stable_ff, stable_in;
   logic                         cand_ff, cand_in;
   logic [tid_pkg::TIME_W-1:0]   since_ff, since_in;
   logic [tid_pkg::TIME_W-1:0]   last_ff, last_in;
   logic [tid_pkg::COUNT_W-1:0]  count_ff, count_in;

   logic                         level;
   logic                         bad_chan;
   logic [tid_pkg::TIME_W-1:0]   eff_since;
   logic [tid_pkg::TIME_W:0]     diff;
   logic                         accept;

   assign level     = item.raw_level ^ cfg.invert;
   assign bad_chan  = {1'b0, item.channel} >= CH_LIMIT;
   assign eff_since = (level != cand_ff) ? item.now_us : since_ff;
   assign diff      = {1'b0, item.now_us} - {1'b0, eff_since};
   assign accept    = !diff[tid_pkg::TIME_W]
                   && (diff[tid_pkg::TIME_W-1:0] >= tid_pkg::TIME_W'(cfg.win_us));

   always_comb begin
      started_in = started_ff;
      stable_in  = stable_ff;
      cand_in    = cand_ff;
      since_in   = since_ff;
      last_in    = last_ff;
      count_in   = count_ff;
      result.status         = tid_pkg::STATUS_OK;
      result.channel_echo   = item.channel;
      result.sample_time_us = '0;
      result.value          = '0;
      if (item.func == tid_pkg::FUNC_INIT) begin
         started_in = 1'b1;
         stable_in  = level;
         cand_in    = level;
         since_in   = item.now_us;
         last_in    = item.now_us;
         count_in   = '0;
         result.sample_time_us = item.now_us;
         result.value          = tid_pkg::COUNT_W'(level);
      end else if (!started_ff) begin
         result.status = tid_pkg::STATUS_NOT_INIT;
      end else if (bad_chan) begin
         result.status = tid_pkg::STATUS_BAD_CHAN;
      end else begin
         if (last_ff != item.now_us) begin
            last_in = item.now_us;
            if (level == stable_ff) begin
               cand_in  = stable_ff;
               since_in = item.now_us;
            end else begin
               cand_in  = level;
               since_in = eff_since;
               if (accept) begin
                  stable_in = level;
                  if (count_ff != '1) begin
                     count_in = count_ff + 1'b1;
                  end
               end
            end
         end
         // the reported time equals now whether or not a sample was taken
         result.sample_time_us = item.now_us;
         result.value = (item.channel == 2'd0) ? tid_pkg::COUNT_W'(stable_in) : count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         stable_ff  <= 1'b0;
         cand_ff    <= 1'b0;
         since_ff   <= '0;
         last_ff    <= '0;
         count_ff   <= '0;
      end else if (fire) begin
         started_ff <= started_in;
         stable_ff  <= stable_in;
         cand_ff    <= cand_in;
         since_ff   <= since_in;
         last_ff    <= last_in;
         count_ff   <= count_in;
      end
   end

endmodule

// ----- rtl/tid_checker.sv -----
// tid_checker: port-level checks for the debouncer, bound to the top level
// depends on timestamped_input_debouncer and tid_pkg

module tid_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [103:0]                rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // error transactions carry zero time and value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != tid_pkg::STATUS_OK) |-> rsp_tdata[98:4] == '0)
      else $error("error result with nonzero payload");

   // level channel reports a single bit
   a_level_bit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == tid_pkg::STATUS_OK) && (rsp_tdata[3:2] == 2'd0)
      |-> rsp_tdata[98:68] == '0)
      else $error("level channel value wider than one bit");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind timestamped_input_debouncer tid_checker u_tid_checker (.*);
